[sv/geo_pkg.sv]
// ---------------------------------------------------------------------------
// geo_pkg: shared types and constants of the geohash encoder
// Field widths, the base32 alphabet, the transaction record that walks
// down the cell chain, and the coordinate to bit-code mapping.
// ---------------------------------------------------------------------------
package geo_pkg;

	localparam int COORD_W = 33;
	localparam int CODE_W  = 32;
	localparam int LEN_W   = 4;
	localparam int CHAR_W  = 7;
	localparam int IDX_W   = 5;

	localparam logic [LEN_W-1:0] HASH_LEN_RESET = 4'd12;

	// geohash base32 alphabet as ascii codes
	localparam logic [CHAR_W-1:0] ALPHABET [32] = '{
		7'd48,  7'd49,  7'd50,  7'd51,  7'd52,  7'd53,  7'd54,  7'd55,
		7'd56,  7'd57,  7'd98,  7'd99,  7'd100, 7'd101, 7'd102, 7'd103,
		7'd104, 7'd106, 7'd107, 7'd109, 7'd110, 7'd112, 7'd113, 7'd114,
		7'd115, 7'd116, 7'd117, 7'd118, 7'd119, 7'd120, 7'd121, 7'd122
	};

	// one coordinate pair in flight along the chain
	typedef struct packed {
		logic              valid;
		logic [LEN_W-1:0]  remaining;
		logic [CODE_W-1:0] lon_code;
		logic [CODE_W-1:0] lat_code;
	} geo_item_t;

	// bisection bits of a coordinate: bit n (msb first) of the result is the
	// n-th bisection decision; out of range values saturate
	function automatic logic [CODE_W-1:0] to_code(input logic signed [COORD_W-1:0] x);
		logic [COORD_W:0] v;
		begin
			v = {x[COORD_W-1], x} + {3'b000, 31'h7FFF_FFFF};
			if (v[COORD_W]) begin
				to_code = '0;
			end else if (v[CODE_W]) begin
				to_code = '1;
			end else begin
				to_code = v[CODE_W-1:0];
			end
		end
	endfunction

endpackage

[sv/geo_cell.sv]
// ---------------------------------------------------------------------------
// geo_cell: one character position of the geohash chain
// Picks its five interleaved bisection bits, looks up the character and
// hands the transaction on to the next cell through its registers.
// ---------------------------------------------------------------------------
module geo_cell #(
	parameter int K = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  geo_pkg::geo_item_t          item_in,
	output geo_pkg::geo_item_t          item_out,
	output logic                        char_valid,
	output logic [geo_pkg::CHAR_W-1:0]  hash_char,
	output logic                        last_char
);

	logic [geo_pkg::IDX_W-1:0]  idx;
	logic                       emit;
	logic                       item_valid_q;
	logic [geo_pkg::LEN_W-1:0]  remaining_q;
	logic [geo_pkg::CODE_W-1:0] lon_code_q;
	logic [geo_pkg::CODE_W-1:0] lat_code_q;
	logic                       valid_q;
	logic                       last_q;
	logic [geo_pkg::CHAR_W-1:0] char_q;

	// bit j of this character is global bit 5K+j; even bits are longitude
	for (genvar j = 0; j < geo_pkg::IDX_W; j++) begin : g_bit
		localparam int G = geo_pkg::IDX_W * K + j;
		localparam int N = G / 2;
		if (G % 2 == 0) begin : g_lon
			assign idx[geo_pkg::IDX_W-1-j] = item_in.lon_code[geo_pkg::CODE_W-1-N];
		end else begin : g_lat
			assign idx[geo_pkg::IDX_W-1-j] = item_in.lat_code[geo_pkg::CODE_W-1-N];
		end
	end

	assign emit = item_in.valid && (item_in.remaining != '0);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= 1'b0;
			item_valid_q <= 1'b0;
		end else begin
			valid_q      <= emit;
			item_valid_q <= emit && (item_in.remaining != geo_pkg::LEN_W'(1));
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		char_q      <= geo_pkg::ALPHABET[idx];
		last_q      <= (item_in.remaining == geo_pkg::LEN_W'(1));
		remaining_q <= item_in.remaining - geo_pkg::LEN_W'(1);
		lon_code_q  <= item_in.lon_code;
		lat_code_q  <= item_in.lat_code;
	end

	// transaction handed to the next cell
	always_comb begin
		item_out.valid     = item_valid_q;
		item_out.remaining = remaining_q;
		item_out.lon_code  = lon_code_q;
		item_out.lat_code  = lat_code_q;
	end

	assign char_valid = valid_q;
	assign hash_char  = char_q;
	assign last_char  = last_q;

endmodule

[sv/geohash_encoder.sv]
// ---------------------------------------------------------------------------
// geohash_encoder: coordinate pair to base32 geohash characters
// Bisection encoder built as a chain of one cell per character position.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken when start is high and busy is
//   low; latitude and longitude are sampled at that edge.
//   Results: one character per cycle on hash_char, marked by char_valid,
//   with last_char on the final one. The receiver cannot stall.
//   Config: cfg_data sets hash_length (1..12, above MAX_HASH_CHARS clamps,
//   zero gives no characters); cfg_ready is always high. Write only idle.
// Flow:
//   character k comes from cell k of the chain, registered there. The output
//   port sets the rate: busy stays high after a transaction while its later
//   characters still hold output slots, so no new pair is taken until then,
//   and the characters of successive pairs follow each other back to back.
// Reset:
//   arst_n clears the chain's valid flags and the busy counter; hash_length returns to 12.
// ---------------------------------------------------------------------------
module geohash_encoder #(
	parameter int MAX_HASH_CHARS = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [geo_pkg::COORD_W-1:0] latitude,
	input  logic signed [geo_pkg::COORD_W-1:0] longitude,
	output logic                               char_valid,
	output logic [geo_pkg::CHAR_W-1:0]         hash_char,
	output logic                               last_char,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [geo_pkg::LEN_W-1:0]          cfg_data
);

	logic [geo_pkg::LEN_W-1:0]  hash_length_q;
	logic [geo_pkg::LEN_W-1:0]  busy_cnt_q;
	logic [geo_pkg::LEN_W-1:0]  count;
	logic                       accept;
	geo_pkg::geo_item_t         link [MAX_HASH_CHARS+1];
	logic                       cell_valid [MAX_HASH_CHARS];
	logic [geo_pkg::CHAR_W-1:0] cell_char  [MAX_HASH_CHARS];
	logic                       cell_last  [MAX_HASH_CHARS];

	assign cfg_ready = 1'b1;
	assign busy      = (busy_cnt_q != '0);
	assign accept    = start && !busy;

	// clamp configured length
	assign count = (hash_length_q > geo_pkg::LEN_W'(MAX_HASH_CHARS))
		? geo_pkg::LEN_W'(MAX_HASH_CHARS) : hash_length_q;

	// length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_length_q <= geo_pkg::HASH_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			hash_length_q <= cfg_data;
		end
	end

	// output slot reservation for the characters of the transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_cnt_q <= '0;
		end else if (accept) begin
			busy_cnt_q <= (count == '0) ? '0 : count - geo_pkg::LEN_W'(1);
		end else if (busy) begin
			busy_cnt_q <= busy_cnt_q - geo_pkg::LEN_W'(1);
		end
	end

	// head of chain
	always_comb begin
		link[0].valid     = accept;
		link[0].remaining = count;
		link[0].lon_code  = geo_pkg::to_code(longitude);
		link[0].lat_code  = geo_pkg::to_code(latitude);
	end

	// character cells
	for (genvar k = 0; k < MAX_HASH_CHARS; k++) begin : g_cell
		geo_cell #(
			.K (k)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.item_in    (link[k]),
			.item_out   (link[k+1]),
			.char_valid (cell_valid[k]),
			.hash_char  (cell_char[k]),
			.last_char  (cell_last[k])
		);
	end

	// merge cell outputs, at most one cell emits per cycle
	always_comb begin
		char_valid = 1'b0;
		hash_char  = '0;
		last_char  = 1'b0;
		for (int k = 0; k < MAX_HASH_CHARS; k++) begin
			char_valid = char_valid | cell_valid[k];
			hash_char  = hash_char | (cell_valid[k] ? cell_char[k] : '0);
			last_char  = last_char | (cell_valid[k] & cell_last[k]);
		end
	end

endmodule

[tb/tb_geohash_encoder.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_geohash_encoder: self-checking testbench of the geohash encoder
// Drives coordinate pairs on the start/busy command channel and sets the
// hash length between phases. A scoreboard predicts every base32 character
// by bisection and checks each strobed result in order, field by field.
// ---------------------------------------------------------------------------

// one expected output character
typedef struct {
	logic [geo_pkg::CHAR_W-1:0] code;
	logic                       last;
} geo_char_t;

// predicts geohash characters for accepted pairs and checks the results
class hash_scoreboard;
	localparam int MAX_CHARS = 12;
	localparam string GEO_ALPHABET = "0123456789bcdefghjkmnpqrstuvwxyz";

	logic [geo_pkg::LEN_W-1:0] hash_length;
	geo_char_t                 expected_chars[$];
	int                        errors;

	function new();
		hash_length = geo_pkg::HASH_LEN_RESET;
		errors = 0;
	endfunction

	task report(string msg);
		errors++;
		$display("tb: mismatch at %0t: %s", $time, msg);
	endtask

	function void set_length(logic [geo_pkg::LEN_W-1:0] len);
		hash_length = len;
	endfunction

	function int pending();
		return expected_chars.size();
	endfunction

	// interval bisection, longitude first, five bits per character
	function void predict_hash(logic signed [geo_pkg::COORD_W-1:0] lat,
			logic signed [geo_pkg::COORD_W-1:0] lon);
		longint    lat_v, lon_v, lat_lo, lat_hi, lon_lo, lon_hi, mid;
		bit        on_lon;
		int        count;
		logic [4:0] idx;
		geo_char_t ch;
		lat_v = lat;
		lon_v = lon;
		lat_lo = -(64'sd1 <<< 31);
		lat_hi = 64'sd1 <<< 31;
		lon_lo = lat_lo;
		lon_hi = lat_hi;
		on_lon = 1'b1;
		count = (hash_length > MAX_CHARS) ? MAX_CHARS : int'(hash_length);
		for (int k = 0; k < count; k++) begin
			idx = '0;
			for (int b = 0; b < 5; b++) begin
				if (on_lon) begin
					mid = lon_lo + (lon_hi - lon_lo) / 2;
					if (lon_v > mid) begin
						idx = {idx[3:0], 1'b1};
						lon_lo = mid;
					end else begin
						idx = {idx[3:0], 1'b0};
						lon_hi = mid;
					end
				end else begin
					mid = lat_lo + (lat_hi - lat_lo) / 2;
					if (lat_v > mid) begin
						idx = {idx[3:0], 1'b1};
						lat_lo = mid;
					end else begin
						idx = {idx[3:0], 1'b0};
						lat_hi = mid;
					end
				end
				on_lon = !on_lon;
			end
			ch.code = geo_pkg::CHAR_W'(GEO_ALPHABET[idx]);
			ch.last = (k == count - 1);
			expected_chars.push_back(ch);
		end
	endfunction

	task check_char(logic [geo_pkg::CHAR_W-1:0] code, logic last);
		geo_char_t ch;
		if (expected_chars.size() == 0) begin
			report($sformatf("unexpected character 0x%02h last %0b", code, last));
		end else begin
			ch = expected_chars.pop_front();
			if (code !== ch.code)
				report($sformatf("hash_char 0x%02h, expected 0x%02h", code, ch.code));
			if (last !== ch.last)
				report($sformatf("last_char %0b, expected %0b", last, ch.last));
		end
	endtask
endclass

module tb_geohash_encoder;
	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 20;
	localparam logic signed [geo_pkg::COORD_W-1:0] C_POS  = 33'h0_8000_0000;
	localparam logic signed [geo_pkg::COORD_W-1:0] C_NEG  = 33'h1_8000_0000;
	localparam logic signed [geo_pkg::COORD_W-1:0] C_MAX  = 33'h0_FFFF_FFFF;
	localparam logic signed [geo_pkg::COORD_W-1:0] C_MIN  = 33'h1_0000_0000;
	localparam logic signed [geo_pkg::COORD_W-1:0] C_HALF = 33'h0_4000_0000;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               start = 1'b0;
	logic                               busy;
	logic signed [geo_pkg::COORD_W-1:0] latitude = '0;
	logic signed [geo_pkg::COORD_W-1:0] longitude = '0;
	logic                               char_valid;
	logic [geo_pkg::CHAR_W-1:0]         hash_char;
	logic                               last_char;
	logic                               cfg_valid = 1'b0;
	logic                               cfg_ready;
	logic [geo_pkg::LEN_W-1:0]          cfg_data = '0;

	hash_scoreboard sb = new();
	int             cycle_count;

	geohash_encoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.latitude   (latitude),
		.longitude  (longitude),
		.char_valid (char_valid),
		.hash_char  (hash_char),
		.last_char  (last_char),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	// observe every transaction at the clock edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.set_length(cfg_data);
			if (start && !busy)
				sb.predict_hash(latitude, longitude);
			if (char_valid)
				sb.check_char(hash_char, last_char);
		end
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	// present one pair and hold it until taken; start stays high afterwards
	task automatic send_pair(logic signed [geo_pkg::COORD_W-1:0] lat,
			logic signed [geo_pkg::COORD_W-1:0] lon);
		start <= 1'b1;
		latitude <= lat;
		longitude <= lon;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// random sender gaps before the next pair
	task automatic idle_gap(int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// hold off until every predicted character has come out
	task automatic drain_chars();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// length write, only with the encoder idle
	task automatic write_length(logic [geo_pkg::LEN_W-1:0] len);
		drain_chars();
		repeat (TAIL_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= len;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// coordinate mix: in range, full field, edges, near midpoints, out of range
	function automatic logic signed [geo_pkg::COORD_W-1:0] rand_coord();
		int                                pick;
		int                                depth;
		int                                offset;
		bit                                top;
		logic signed [31:0]                r;
		logic signed [geo_pkg::COORD_W-1:0] v;
		pick = $urandom_range(0, 9);
		r = $urandom;
		top = 1'($urandom_range(0, 1));
		if (pick <= 5) begin
			v = r;
		end else if (pick == 6) begin
			v = {top, r};
		end else if (pick == 7) begin
			case ($urandom_range(0, 5))
				0: v = C_POS;
				1: v = C_NEG;
				2: v = C_POS + 33'sd1;
				3: v = C_NEG - 33'sd1;
				4: v = '0;
				default: v = -33'sd1;
			endcase
		end else if (pick == 8) begin
			depth = $urandom_range(1, 30);
			offset = $urandom_range(0, 2);
			v = r;
			v = (v >>> (31 - depth)) <<< (31 - depth);
			v = v + geo_pkg::COORD_W'(offset) - 33'sd1;
		end else begin
			v = {top, ~top, r[30:0]};
		end
		return v;
	endfunction

	initial begin
		int seg_len [8];
		int seg_idle [8];
		int len;

		seg_len = '{12, 1, 7, 14, 3, 12, 0, 5};
		seg_idle = '{0, 0, 67, 67, 0, 0, 14, 14};

		// reset
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pairs at the reset length
		send_pair(C_NEG, C_NEG);
		send_pair(C_POS, C_POS);
		send_pair('0, '0);
		send_pair(-33'sd1, 33'sd1);
		send_pair(C_MIN, C_MAX);
		send_pair(C_MAX, C_MIN);
		send_pair(C_POS + 33'sd1, C_NEG - 33'sd1);
		send_pair(C_HALF, -C_HALF);
		send_pair(C_HALF + 33'sd1, -C_HALF + 33'sd1);
		send_pair(33'sd2, 33'sd3);
		send_pair(33'sd1, -33'sd1);

		// zero length gives no characters
		write_length(4'd0);
		send_pair(33'sd123, 33'sd456);
		send_pair(C_POS, C_NEG);

		// lengths above the maximum clamp
		write_length(4'd15);
		send_pair(C_HALF, C_HALF);
		write_length(4'd13);
		send_pair(-C_HALF, 33'sd77);

		// single character
		write_length(4'd1);
		send_pair(C_POS, C_NEG);
		send_pair(C_NEG, C_POS);

		// random segments, each with its own length and sender idling
		for (int s = 0; s < 8; s++) begin
			len = (seg_len[s] == 0) ? $urandom_range(1, 12) : seg_len[s];
			write_length(len[geo_pkg::LEN_W-1:0]);
			for (int i = 0; i < 32; i++) begin
				if (i == 16)
					drain_chars();
				idle_gap(seg_idle[s]);
				send_pair(rand_coord(), rand_coord());
			end
		end

		// end of run
		drain_chars();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d characters never arrived", sb.pending()));
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
